// ===== hdl/prd_pkg.sv =====
package prd_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [15:0] QUANTUM_RST = 16'd10;
    localparam logic [19:0] TIME_MAX    = 20'hFFFFF;
    localparam logic [23:0] SUM_MAX     = 24'hFFFFFF;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_PICK,
        S_GRANT,
        S_FINISH,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  task_id;
        logic [3:0]  task_priority;
        logic [15:0] task_burst;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  granted_id;
        logic [15:0] slice_length;
        logic [19:0] slice_start;
        logic        task_finished;
        logic        all_done;
        logic [23:0] wait_sum;
        logic [23:0] turnaround_sum;
        logic [23:0] response_sum;
        logic [4:0]  tasks_held;
    } result_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [3:0]  prio;
        logic [15:0] rem;
        logic [15:0] orig;
        logic        started;
        logic        valid;
    } slot_t;

    // Ripple signals handed from one cell to the next
    typedef struct packed {
        logic       keep;
        logic       found;
        logic [3:0] lvl;
        logic       ge;
        logic       any;
        logic       m1;
        logic       m2;
    } link_t;

    typedef struct packed {
        logic insert;
        logic clear;
        logic pick;
        logic grant;
    } ctrl_t;

endpackage

// ===== hdl/prd_cell.sv =====
module prd_cell #(
    parameter int IDX  = 0,
    parameter int CNTW = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prd_pkg::ctrl_t    ctrl,
    input  prd_pkg::slot_t    new_task,
    input  prd_pkg::slot_t    prev_slot,
    input  prd_pkg::link_t    link_in,
    output prd_pkg::link_t    link_out,
    input  logic [3:0]        lvl,
    input  logic [CNTW-1:0]   cursor,
    input  logic              ge_found,
    input  logic [15:0]       len,
    output prd_pkg::slot_t    slot,
    output logic              sel
);

    logic [7:0]  id_reg;
    logic [3:0]  prio_reg;
    logic [15:0] rem_reg;
    logic [15:0] orig_reg;
    logic        started_reg;
    logic        valid_reg;
    logic        sel_reg;
    logic        keep;
    logic        take_new;
    logic        active;
    logic        inlvl;
    logic        cand;
    logic        ge;
    logic        pick_me;

    assign keep     = valid_reg && (prio_reg >= new_task.prio);
    assign take_new = !keep && link_in.keep;
    assign active   = valid_reg && (rem_reg != 16'd0);
    assign inlvl    = valid_reg && (prio_reg == lvl);
    assign cand     = active && inlvl;
    assign ge       = cand && (CNTW'(IDX) >= cursor);
    assign pick_me  = ge_found ? (ge && !link_in.ge) : (cand && !link_in.any);

    always_comb
    begin
        link_out.keep  = keep;
        link_out.found = link_in.found || active;
        link_out.lvl   = (!link_in.found && active) ? prio_reg : link_in.lvl;
        link_out.ge    = link_in.ge || ge;
        link_out.any   = link_in.any || cand;
        link_out.m1    = link_in.m1 || inlvl;
        link_out.m2    = link_in.m2 || (link_in.m1 && inlvl);
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && !keep)
        begin
            id_reg   <= take_new ? new_task.id   : prev_slot.id;
            prio_reg <= take_new ? new_task.prio : prev_slot.prio;
            rem_reg  <= take_new ? new_task.rem  : prev_slot.rem;
            orig_reg <= take_new ? new_task.orig : prev_slot.orig;
        end
        else if (ctrl.grant && sel_reg)
        begin
            rem_reg <= rem_reg - len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg   <= 1'b0;
                started_reg <= 1'b0;
            end
            else if (ctrl.insert && !keep)
            begin
                valid_reg   <= take_new ? 1'b1 : prev_slot.valid;
                started_reg <= take_new ? 1'b0 : prev_slot.started;
            end
            else if (ctrl.grant && sel_reg)
            begin
                started_reg <= 1'b1;
            end
            if (ctrl.pick)
            begin
                sel_reg <= pick_me;
            end
        end
    end

    always_comb
    begin
        slot.id      = id_reg;
        slot.prio    = prio_reg;
        slot.rem     = rem_reg;
        slot.orig    = orig_reg;
        slot.started = started_reg;
        slot.valid   = valid_reg;
    end

    assign sel = sel_reg;

endmodule

// ===== hdl/priority_round_robin_dispatcher.sv =====
// Channel   Handshake            Word                        Notes
// command   start / busy         cmd (prd_pkg::cmd_t)        taken when start && !busy
// result    done                 result (prd_pkg::result_t)  one cycle, cannot stall
// config    cfg_we               cfg_wdata (quantum)         written at once, no read-back
//
// Add, clear and unused commands go straight to report and return their word;
// dispatch runs level search, round robin pick, grant, sum update and report
// in turn. A dispatch that finds no work skips from level search to report.
// Reset clears the table, time, sums and cursor and sets quantum to 10.
// busy is high from the cycle after acceptance until the result cycle, so the
// next command can be taken at the edge that ends the result word.
module priority_round_robin_dispatcher #(
    parameter int MAX_TASKS = prd_pkg::MAX_TASKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  prd_pkg::cmd_t    cmd,
    output logic             done,
    output prd_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata
);

    localparam int IDXW = $clog2(MAX_TASKS);
    localparam int CNTW = $clog2(MAX_TASKS + 1);

    prd_pkg::state_t  state_reg, state_next;
    prd_pkg::ctrl_t   ctrl;
    prd_pkg::slot_t   new_task;
    prd_pkg::slot_t   slots [MAX_TASKS];
    prd_pkg::link_t   links [MAX_TASKS + 1];
    prd_pkg::slot_t   pick_slot;
    prd_pkg::result_t result_reg;

    logic [MAX_TASKS-1:0] keep_vec;
    logic [MAX_TASKS-1:0] sel_vec;
    logic [CNTW-1:0]      total_reg;
    logic [CNTW-1:0]      cursor_reg;
    logic [CNTW-1:0]      pick_idx;
    logic [15:0]          quantum_reg;
    logic [15:0]          q_eff;
    logic [15:0]          len;
    logic [19:0]          now_reg;
    logic [23:0]          wait_reg, turn_reg, resp_reg;
    logic [3:0]           lvl_reg;
    logic                 gt1_reg;
    logic                 done_reg;
    logic                 accept;
    logic                 full;
    logic                 p_below;
    logic [1:0]           status_reg;
    logic [7:0]           gid_reg;
    logic [15:0]          glen_reg;
    logic [19:0]          gstart_reg;
    logic [15:0]          orig_reg;
    logic                 gfin_reg;
    logic [20:0]          now_sum;
    logic [24:0]          resp_sum;
    logic [19:0]          wait_one;
    logic [24:0]          wait_add;
    logic [24:0]          turn_add;

    assign accept = start && (state_reg == prd_pkg::S_IDLE);
    assign full   = (total_reg >= CNTW'(MAX_TASKS));

    // Insertion point lies below the cursor when the slot just under it is not kept
    assign p_below = (cursor_reg != '0) && !keep_vec[IDXW'(cursor_reg - CNTW'(1))];

    always_comb
    begin
        new_task.id      = cmd.task_id;
        new_task.prio    = cmd.task_priority;
        new_task.rem     = cmd.task_burst;
        new_task.orig    = cmd.task_burst;
        new_task.started = 1'b0;
        new_task.valid   = 1'b1;
    end

    assign links[0] = '{keep: 1'b1, found: 1'b0, lvl: 4'd0, ge: 1'b0,
                        any: 1'b0, m1: 1'b0, m2: 1'b0};

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        prd_cell #(
            .IDX  (i),
            .CNTW (CNTW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_task  (new_task),
            .prev_slot ((i == 0) ? '0 : slots[(i == 0) ? 0 : i - 1]),
            .link_in   (links[i]),
            .link_out  (links[i+1]),
            .lvl       (lvl_reg),
            .cursor    (cursor_reg),
            .ge_found  (links[MAX_TASKS].ge),
            .len       (len),
            .slot      (slots[i]),
            .sel       (sel_vec[i])
        );
        assign keep_vec[i] = links[i+1].keep;
    end

    // Gather the selected slot and its index
    always_comb
    begin
        pick_slot = '0;
        pick_idx  = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (sel_vec[i])
            begin
                pick_slot = pick_slot | slots[i];
                pick_idx  = pick_idx | CNTW'(i);
            end
        end
    end

    assign q_eff    = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign len      = (gt1_reg && (pick_slot.rem > q_eff)) ? q_eff : pick_slot.rem;
    assign now_sum  = {1'b0, now_reg} + {5'd0, len};
    assign resp_sum = {1'b0, resp_reg} + {5'd0, now_reg};
    assign wait_one = (now_reg > {4'd0, orig_reg}) ? (now_reg - {4'd0, orig_reg}) : 20'd0;
    assign wait_add = {1'b0, wait_reg} + {5'd0, wait_one};
    assign turn_add = {1'b0, turn_reg} + {5'd0, now_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prd_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = (cmd.operation == prd_pkg::OP_DISPATCH) ?
                                 prd_pkg::S_LEVEL : prd_pkg::S_REPORT;
            end
            prd_pkg::S_LEVEL:
                state_next = links[MAX_TASKS].found ? prd_pkg::S_PICK : prd_pkg::S_REPORT;
            prd_pkg::S_PICK:   state_next = prd_pkg::S_GRANT;
            prd_pkg::S_GRANT:  state_next = prd_pkg::S_FINISH;
            prd_pkg::S_FINISH: state_next = prd_pkg::S_REPORT;
            prd_pkg::S_REPORT: state_next = prd_pkg::S_IDLE;
            default:           state_next = prd_pkg::S_IDLE;
        endcase
    end

    // Cell controls
    always_comb
    begin
        ctrl   = '0;
        busy   = 1'b1;
        case (state_reg)
            prd_pkg::S_IDLE:
            begin
                busy        = 1'b0;
                ctrl.insert = accept && (cmd.operation == prd_pkg::OP_ADD) && !full;
                ctrl.clear  = accept && (cmd.operation == prd_pkg::OP_CLEAR);
            end
            prd_pkg::S_PICK:  ctrl.pick  = 1'b1;
            prd_pkg::S_GRANT: ctrl.grant = 1'b1;
            default:          ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= prd_pkg::S_IDLE;
            quantum_reg <= prd_pkg::QUANTUM_RST;
            total_reg   <= '0;
            cursor_reg  <= '0;
            now_reg     <= '0;
            wait_reg    <= '0;
            turn_reg    <= '0;
            resp_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == prd_pkg::S_REPORT);
            if (cfg_we)
                quantum_reg <= cfg_wdata;
            if (ctrl.insert)
            begin
                total_reg <= total_reg + CNTW'(1);
                if (p_below)
                    cursor_reg <= cursor_reg + CNTW'(1);
            end
            if (ctrl.clear)
            begin
                total_reg  <= '0;
                cursor_reg <= '0;
                now_reg    <= '0;
                wait_reg   <= '0;
                turn_reg   <= '0;
                resp_reg   <= '0;
            end
            if (ctrl.grant)
            begin
                // Advance time and take the first-run response
                now_reg    <= now_sum[20] ? prd_pkg::TIME_MAX : now_sum[19:0];
                cursor_reg <= pick_idx + CNTW'(1);
                if (!pick_slot.started)
                    resp_reg <= resp_sum[24] ? prd_pkg::SUM_MAX : resp_sum[23:0];
            end
            if ((state_reg == prd_pkg::S_FINISH) && gfin_reg)
            begin
                wait_reg <= wait_add[24] ? prd_pkg::SUM_MAX : wait_add[23:0];
                turn_reg <= turn_add[24] ? prd_pkg::SUM_MAX : turn_add[23:0];
            end
        end
    end

    // Grant word and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= (cmd.operation == prd_pkg::OP_ADD && full) ?
                          prd_pkg::ST_FULL : prd_pkg::ST_OK;
            gid_reg    <= '0;
            glen_reg   <= '0;
            gstart_reg <= '0;
            gfin_reg   <= 1'b0;
        end
        if (state_reg == prd_pkg::S_LEVEL)
        begin
            lvl_reg <= links[MAX_TASKS].lvl;
            if (!links[MAX_TASKS].found)
                status_reg <= prd_pkg::ST_EMPTY;
        end
        if (state_reg == prd_pkg::S_PICK)
            gt1_reg <= links[MAX_TASKS].m2;
        if (ctrl.grant)
        begin
            gid_reg    <= pick_slot.id;
            glen_reg   <= len;
            gstart_reg <= now_reg;
            orig_reg   <= pick_slot.orig;
            gfin_reg   <= (pick_slot.rem == len);
        end
        if (state_reg == prd_pkg::S_REPORT)
        begin
            result_reg.status         <= status_reg;
            result_reg.granted_id     <= gid_reg;
            result_reg.slice_length   <= glen_reg;
            result_reg.slice_start    <= gstart_reg;
            result_reg.task_finished  <= gfin_reg;
            result_reg.all_done       <= !links[MAX_TASKS].found;
            result_reg.wait_sum       <= wait_reg;
            result_reg.turnaround_sum <= turn_reg;
            result_reg.response_sum   <= resp_reg;
            result_reg.tasks_held     <= 5'(total_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
